[rtl/nfa_pkg.sv]
// Shared constants and codes for the automaton string acceptor.
`default_nettype none

package nfa_pkg;

  // Default automaton size.
  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_SYMBOLS_DEF = 16;

  // Fixed field widths of the request and result channels.
  localparam int OP_W    = 2;
  localparam int SYM_W   = 4;
  localparam int STATE_W = 4;
  localparam int MASK_W  = 16;
  localparam int VERD_W  = 2;
  localparam int CIDX_W  = 2;

  // Request operations.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_END    = 2'd2
  } op_t;

  // Verdict codes; V_ACCEPT also marks a string that is still alive.
  typedef enum logic [VERD_W-1:0] {
    V_ACCEPT     = 2'd0,
    V_NO_ACCEPT  = 2'd1,
    V_BAD_SYMBOL = 2'd2,
    V_NO_TRANS   = 2'd3
  } verdict_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_ACCEPT = 2'd1,
    CFG_ENABLE = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/nfa_string_acceptor.sv]
// Top level of the automaton string acceptor with its transition table memory.
//
// Usage: requests arrive on in_valid/in_stall with operation, is_epsilon,
// symbol_code, from_state and target_mask. A write request stores one row of
// the transition table. A symbol request walks the active set by reading one
// table row per state from the synchronous table memory in the scan state,
// then folds the last row into the new active set in the finish state; no
// request is accepted until it ends. An end request puts one result
// (verdict, final_active) in the output register, where it stays until
// taken on out_valid/out_stall. The next request is accepted while a result
// waits; an end request that finds the output register still full waits in
// the block until the receiver takes the earlier result.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// writing the start state restarts the current string.
// After reset a clearing pass zeroes the table, one row per cycle, over all
// min(NUM_STATES,16) * (min(NUM_SYMBOLS,16) + 1) rows; no request is accepted
// during it, while configuration writes are taken.
`default_nettype none

module nfa_string_acceptor #(
  parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nfa_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [nfa_pkg::OP_W-1:0]     operation,
  input  wire logic                         is_epsilon,
  input  wire logic [nfa_pkg::SYM_W-1:0]    symbol_code,
  input  wire logic [nfa_pkg::STATE_W-1:0]  from_state,
  input  wire logic [nfa_pkg::MASK_W-1:0]   target_mask,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [nfa_pkg::VERD_W-1:0]        verdict,
  output logic [nfa_pkg::MASK_W-1:0]        final_active,
  // Configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [nfa_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [nfa_pkg::MASK_W-1:0]   cfg_data
);
  import nfa_pkg::*;

  // Only states and codes that the field widths can name are stored.
  localparam int EFF_STATES = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
  localparam int EFF_SYMS   = (NUM_SYMBOLS < (1 << SYM_W)) ? NUM_SYMBOLS : (1 << SYM_W);
  localparam int EFF_COLS   = EFF_SYMS + 1;
  localparam int DEPTH      = EFF_STATES * EFF_COLS;
  localparam int ACT_W      = EFF_STATES;
  localparam int ST_W       = $clog2(EFF_STATES);
  localparam int COL_W      = $clog2(EFF_COLS);
  localparam int ADDR_W     = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_HOLD
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ST_W-1:0]   scan_idx;
  logic [COL_W-1:0]  scan_col;
  logic [ACT_W-1:0]  acc;
  logic              rd_use;
  logic [ACT_W-1:0]  active;
  verdict_t          status;

  logic [STATE_W-1:0] start_state;
  logic [MASK_W-1:0]  accepting_states;
  logic [MASK_W-1:0]  symbol_enable;

  // Table memory ports.
  logic [ACT_W-1:0]  mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ACT_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ACT_W-1:0]  rd_data;

  logic              in_take;
  logic              out_free;
  logic              res_load;
  logic              wr_ok;
  logic [COL_W-1:0]  wr_col;
  logic              sym_ok;
  logic [ACT_W-1:0]  acc_next;
  verdict_t          end_verdict;

  // Row address of a (state, column) pair.
  function automatic logic [ADDR_W-1:0] row_addr(input logic [ST_W-1:0] st,
                                                 input logic [COL_W-1:0] col);
    row_addr = ADDR_W'(st) * ADDR_W'(EFF_COLS) + ADDR_W'(col);
  endfunction

  // One-hot active set of a fresh string.
  function automatic logic [ACT_W-1:0] start_set(input logic [STATE_W-1:0] st);
    logic [ACT_W-1:0] one;
    one = {{(ACT_W-1){1'b0}}, 1'b1};
    if (32'(st) < EFF_STATES) begin
      start_set = one << st;
    end else begin
      start_set = '0;
    end
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // A new result loads into the output register this cycle.
  assign res_load  = (in_take && (operation == OP_END) && out_free)
                     || ((state == S_HOLD) && out_free);

  // Decode of the write and symbol requests.
  assign wr_ok  = (32'(from_state) < NUM_STATES)
                  && (is_epsilon || (32'(symbol_code) < NUM_SYMBOLS));
  assign wr_col = is_epsilon ? COL_W'(EFF_SYMS) : COL_W'(symbol_code);
  assign sym_ok = is_epsilon
                  || ((32'(symbol_code) < NUM_SYMBOLS) && symbol_enable[symbol_code]);

  // Running OR of the rows read so far, including the one arriving now.
  assign acc_next = acc | (rd_use ? rd_data : '0);

  // Verdict of the current string.
  always_comb begin
    if (status != V_ACCEPT) begin
      end_verdict = status;
    end else if (|(active & accepting_states[ACT_W-1:0])) begin
      end_verdict = V_ACCEPT;
    end else begin
      end_verdict = V_NO_ACCEPT;
    end
  end

  // Memory port selection: clearing pass, row writes and the scan reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = row_addr(scan_idx, scan_col);
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_take && (operation == OP_WRITE) && wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = row_addr(ST_W'(from_state), wr_col);
      mem_wdata = target_mask[ACT_W-1:0];
    end
  end

  // Transition table with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Control, string state, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      scan_idx         <= '0;
      rd_use           <= 1'b0;
      active           <= start_set('0);
      status           <= V_ACCEPT;
      start_state      <= '0;
      accepting_states <= '0;
      symbol_enable    <= '1;
      out_valid        <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one loads now.
      if (out_valid && !out_stall && !res_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_take) begin
            case (op_t'(operation))
              OP_SYMBOL: begin
                if (status == V_ACCEPT) begin
                  if (!sym_ok) begin
                    status <= V_BAD_SYMBOL;
                  end else begin
                    scan_col <= wr_col;
                    scan_idx <= '0;
                    acc      <= '0;
                    rd_use   <= 1'b0;
                    state    <= S_SCAN;
                  end
                end
              end
              OP_END: begin
                if (out_free) begin
                  out_valid    <= 1'b1;
                  verdict      <= end_verdict;
                  final_active <= MASK_W'(active);
                  active       <= start_set(start_state);
                  status       <= V_ACCEPT;
                end else begin
                  state <= S_HOLD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // One row read issued per cycle; its registered data is folded in on the next cycle.
        S_SCAN: begin
          acc      <= acc_next;
          rd_use   <= active[scan_idx];
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == ST_W'(EFF_STATES - 1)) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (acc_next == '0) begin
            status <= V_NO_TRANS;
          end else begin
            active <= acc_next;
          end
          state <= S_IDLE;
        end

        // An end request waits here until the output register is free.
        S_HOLD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            verdict      <= end_verdict;
            final_active <= MASK_W'(active);
            active       <= start_set(start_state);
            status       <= V_ACCEPT;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes are to arrive only while the block is idle; the block does not enforce this.
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START: begin
            start_state <= cfg_data[STATE_W-1:0];
            active      <= start_set(cfg_data[STATE_W-1:0]);
            status      <= V_ACCEPT;
          end
          CFG_ACCEPT: begin
            accepting_states <= cfg_data;
          end
          CFG_ENABLE: begin
            symbol_enable <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // No request is taken before the clearing pass ends.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  // A held end request always sits behind a pending result.
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> out_valid)
    else $error("end request held with an empty output register");

  // The table is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_FINISH)) |-> !mem_we)
    else $error("table written during a scan");

  // The finishing step follows the last scan read.
  a_finish_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> ($past(state) == S_SCAN))
    else $error("scan finished without reading rows");

  // A failed string only carries a rejecting code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    (status != V_ACCEPT) |-> ((status == V_BAD_SYMBOL) || (status == V_NO_TRANS)))
    else $error("string status holds an invalid code");

endmodule

`default_nettype wire
